### hdl/ctsg_pkg.sv
`default_nettype none

package ctsg_pkg;

  // Default build values for the top-level parameters.
  localparam int MAX_LINES_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  // Configuration port geometry: four 32-bit registers at byte offsets 0..12.
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_RIGHT  = 2'd1,
    REG_CLIP_TOP    = 2'd2,
    REG_CLIP_BOTTOM = 2'd3
  } reg_idx_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } ctrl_state_e;

  // One trapezoid as it enters the block.
  typedef struct packed {
    logic signed [31:0] edge_a_x;
    logic signed [31:0] edge_b_x;
    logic signed [31:0] edge_a_step;
    logic signed [31:0] edge_b_step;
    logic signed [15:0] start_row;
    logic        [6:0]  line_count;
  } in_t;

  // One span result.
  typedef struct packed {
    logic               draw;
    logic signed [15:0] span_x;
    logic signed [15:0] span_row;
    logic        [15:0] span_width;
    logic               last;
    logic signed [31:0] end_a_x;
    logic signed [31:0] end_b_x;
    logic signed [15:0] end_row;
  } out_t;

  // Clip rectangle as held by the register file.
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [15:0] top;
    logic signed [15:0] bottom;
  } clip_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture a new trapezoid
    logic issue;  // start one line in the first stage
    logic last;   // the issued line is the final one
    logic empty;  // trapezoid has a zero line count
    logic adv2;   // first stage moves into the second
    logic adv3;   // second stage moves into the output register
  } ctrl_cmd_t;

endpackage

`default_nettype wire

### hdl/ctsg_regs.sv
`default_nettype none

module ctsg_regs
  import ctsg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output clip_t                  clip_o
);

  clip_t    clip_q, clip_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[3:2]);
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;

  // Register write decode.
  always_comb begin
    clip_d = clip_q;
    if (wr_en) begin
      unique case (idx)
        REG_CLIP_LEFT:   clip_d.left   = pwdata[15:0];
        REG_CLIP_RIGHT:  clip_d.right  = pwdata[15:0];
        REG_CLIP_TOP:    clip_d.top    = pwdata[15:0];
        REG_CLIP_BOTTOM: clip_d.bottom = pwdata[15:0];
        default:         clip_d = clip_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= '0;
    end else begin
      clip_q <= clip_d;
    end
  end

  // Read mux; values come back sign-extended.
  always_comb begin
    unique case (idx)
      REG_CLIP_LEFT:   prdata = APB_DW'(clip_q.left);
      REG_CLIP_RIGHT:  prdata = APB_DW'(clip_q.right);
      REG_CLIP_TOP:    prdata = APB_DW'(clip_q.top);
      REG_CLIP_BOTTOM: prdata = APB_DW'(clip_q.bottom);
      default:         prdata = '0;
    endcase
  end

  assign clip_o = clip_q;

endmodule

`default_nettype wire

### hdl/ctsg_ctrl.sv
`default_nettype none

module ctsg_ctrl
  import ctsg_pkg::*;
#(
  parameter int MAX_LINES = MAX_LINES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [6:0] line_count_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output ctrl_cmd_t       cmd_o
);

  localparam int LCW = $clog2(MAX_LINES + 1);

  ctrl_state_e    state_q, state_d;
  logic [LCW-1:0] lines_q, lines_d;
  logic           zero_q, zero_d;
  logic           v1_q, v1_d, v2_q, v2_d, v3_q, v3_d;
  logic           accept;
  logic [LCW-1:0] count_sat;
  logic           run;

  // Line count saturated to the build limit.
  assign count_sat = (line_count_i > 7'(MAX_LINES)) ? LCW'(MAX_LINES)
                                                    : LCW'(line_count_i);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (cmd_o.issue && cmd_o.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output and command logic; the three pipeline stages advance when the
  // stage ahead is empty or is emptying in this cycle.
  always_comb begin
    run         = (state_q == ST_RUN);
    in_ready_o  = (state_q == ST_IDLE);
    accept      = in_valid_i && in_ready_o;
    cmd_o.adv3  = v2_q && (!v3_q || out_ready_i);
    cmd_o.adv2  = v1_q && (!v2_q || cmd_o.adv3);
    cmd_o.issue = run && (!v1_q || cmd_o.adv2);
    cmd_o.load  = accept;
    cmd_o.empty = zero_q;
    cmd_o.last  = zero_q || (lines_q == LCW'(1));
    out_valid_o = v3_q;
  end

  // Stage valid bits and the line counter.
  always_comb begin
    v1_d    = cmd_o.issue ? 1'b1 : (cmd_o.adv2 ? 1'b0 : v1_q);
    v2_d    = cmd_o.adv2 ? 1'b1 : (cmd_o.adv3 ? 1'b0 : v2_q);
    v3_d    = cmd_o.adv3 ? 1'b1 : (out_ready_i ? 1'b0 : v3_q);
    lines_d = lines_q;
    zero_d  = zero_q;
    if (accept) begin
      lines_d = count_sat;
      zero_d  = (count_sat == '0);
    end else if (cmd_o.issue && !zero_q) begin
      lines_d = lines_q - LCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lines_q <= '0;
      zero_q  <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      lines_q <= lines_d;
      zero_q  <= zero_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
      v3_q    <= v3_d;
    end
  end

  // An accepted trapezoid always starts line generation.
  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_RUN)
    else $error("accepted transaction did not start line generation");

  // Issuing the final line returns the controller to idle.
  a_last_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.issue && cmd_o.last) |=> state_q == ST_IDLE)
    else $error("controller kept running after the final line");

  // While running, a non-empty trapezoid has lines left.
  a_lines_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && !zero_q) |-> lines_q != '0)
    else $error("running with no lines left");

  // The counter never exceeds the build limit.
  a_lines_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lines_q <= LCW'(MAX_LINES))
    else $error("line counter above limit");

  // A stalled result is held until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !out_ready_i) |=> v3_q && !$past(cmd_o.adv3))
    else $error("stalled result was replaced");

endmodule

`default_nettype wire

### hdl/ctsg_dp.sv
`default_nettype none

module ctsg_dp
  import ctsg_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire in_t       in_data_i,
  input  wire clip_t     clip_i,
  input  wire ctrl_cmd_t cmd_i,
  output out_t           out_data_o
);

  // Width of a rounded pixel and of the common compare width with the clips.
  localparam int RW = 33 - FRAC_BITS;
  localparam int CW = (RW > 16) ? RW : 16;

  // Walking edge state.
  logic signed [31:0] cur_a_q, cur_b_q, step_a_q, step_b_q;
  logic signed [15:0] cur_row_q;
  logic signed [31:0] next_a, next_b;
  logic signed [15:0] next_row;

  // Stage 1: rounded edges.
  logic signed [CW-1:0] s1_pa_q, s1_pb_q;
  logic signed [15:0]   s1_row_q;
  logic                 s1_in_q, s1_last_q;
  logic signed [31:0]   s1_end_a_q, s1_end_b_q;
  logic signed [15:0]   s1_end_row_q;

  // Stage 2: ordered edges.
  logic signed [CW-1:0] s2_lo_q, s2_hi_q;
  logic signed [15:0]   s2_row_q;
  logic                 s2_in_q, s2_last_q;
  logic signed [31:0]   s2_end_a_q, s2_end_b_q;
  logic signed [15:0]   s2_end_row_q;

  out_t out_q;

  logic signed [32:0]   sum_a, sum_b;
  logic signed [CW-1:0] pa, pb;
  logic                 row_in;
  logic signed [CW-1:0] clip_l, clip_r, lo_c, hi_c;
  logic signed [CW:0]   diff;
  logic                 draw;

  assign next_a   = cur_a_q + step_a_q;
  assign next_b   = cur_b_q + step_b_q;
  assign next_row = cur_row_q + 16'sd1;

  // Round to nearest pixel: add one half, then arithmetic shift.
  always_comb begin
    sum_a  = 33'(cur_a_q) + (33'sd1 <<< (FRAC_BITS - 1));
    sum_b  = 33'(cur_b_q) + (33'sd1 <<< (FRAC_BITS - 1));
    pa     = CW'($signed(sum_a[32:FRAC_BITS]));
    pb     = CW'($signed(sum_b[32:FRAC_BITS]));
    row_in = !cmd_i.empty && (cur_row_q >= clip_i.top) && (cur_row_q < clip_i.bottom);
  end

  // Edge state: loaded per trapezoid, stepped once per issued line of a non-empty trapezoid.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_a_q   <= in_data_i.edge_a_x;
      cur_b_q   <= in_data_i.edge_b_x;
      step_a_q  <= in_data_i.edge_a_step;
      step_b_q  <= in_data_i.edge_b_step;
      cur_row_q <= in_data_i.start_row;
    end else if (cmd_i.issue && !cmd_i.empty) begin
      cur_a_q   <= next_a;
      cur_b_q   <= next_b;
      cur_row_q <= next_row;
    end
  end

  // Stage 1 register; end fields are only carried on the final line.
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      s1_pa_q   <= pa;
      s1_pb_q   <= pb;
      s1_row_q  <= cur_row_q;
      s1_in_q   <= row_in;
      s1_last_q <= cmd_i.last;
      if (!cmd_i.last) begin
        s1_end_a_q   <= '0;
        s1_end_b_q   <= '0;
        s1_end_row_q <= '0;
      end else if (cmd_i.empty) begin
        s1_end_a_q   <= cur_a_q;
        s1_end_b_q   <= cur_b_q;
        s1_end_row_q <= cur_row_q;
      end else begin
        s1_end_a_q   <= next_a;
        s1_end_b_q   <= next_b;
        s1_end_row_q <= next_row;
      end
    end
  end

  // Stage 2: put the smaller edge first.
  always_ff @(posedge clk_i) begin
    if (cmd_i.adv2) begin
      if (s1_pb_q < s1_pa_q) begin
        s2_lo_q <= s1_pb_q;
        s2_hi_q <= s1_pa_q;
      end else begin
        s2_lo_q <= s1_pa_q;
        s2_hi_q <= s1_pb_q;
      end
      s2_row_q     <= s1_row_q;
      s2_in_q      <= s1_in_q;
      s2_last_q    <= s1_last_q;
      s2_end_a_q   <= s1_end_a_q;
      s2_end_b_q   <= s1_end_b_q;
      s2_end_row_q <= s1_end_row_q;
    end
  end

  // Stage 3: clamp to the clip columns and measure the span.
  always_comb begin
    clip_l = CW'(clip_i.left);
    clip_r = CW'(clip_i.right);
    lo_c   = (s2_lo_q < clip_l) ? clip_l : s2_lo_q;
    hi_c   = (s2_hi_q > clip_r) ? clip_r : s2_hi_q;
    diff   = (CW+1)'(hi_c) - (CW+1)'(lo_c);
    draw   = s2_in_q && (lo_c < hi_c);
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.adv3) begin
      out_q.draw       <= draw;
      out_q.span_x     <= draw ? lo_c[15:0] : 16'sd0;
      out_q.span_row   <= s2_row_q;
      out_q.span_width <= draw ? diff[15:0] : 16'd0;
      out_q.last       <= s2_last_q;
      out_q.end_a_x    <= s2_end_a_q;
      out_q.end_b_x    <= s2_end_b_q;
      out_q.end_row    <= s2_end_row_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

### hdl/clipped_trapezoid_span_gen.sv
`default_nettype none
// An accepted trapezoid loads the single edge walker; each line goes through
// the first stage, the second stage and the output register, one span and one
// walker step per cycle unless the output stalls. A trapezoid of n lines (n
// saturated to MAX_LINES, zero counted as one) blocks input until fully issued.
// Reset: rst_ni is asynchronous, active low; it clears the clip registers to
// zero, the controller to idle and all pipeline valid bits.

module clipped_trapezoid_span_gen
  import ctsg_pkg::*;
#(
  parameter int MAX_LINES = MAX_LINES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_t               in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_t                   out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  clip_t     clip;
  ctrl_cmd_t cmd;

  ctsg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .clip_o  (clip)
  );

  ctsg_ctrl #(
    .MAX_LINES (MAX_LINES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .line_count_i (in_data_i.line_count),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd)
  );

  ctsg_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .clip_i     (clip),
    .cmd_i      (cmd),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

### test/tb.sv
`default_nettype none

module tb;
  import ctsg_pkg::*;

  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int LINE_CAP    = MAX_LINES_DEF;
  localparam int RAND_ITEMS  = 300;
  localparam int PHASE_ITEMS = 50;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 10;

  // One row of the directed table. A row may first move the clip window.
  typedef struct {
    in_t   trap;
    bit    known;
    out_t  want;
    bit    reclip;
    clip_t clip;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  in_t  in_data = '0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Clip window as the block should hold it, and the spans still owed.
  clip_t       clip_now = '0;
  out_t        spans_due[$];
  plan_row_t   plan[$];

  int mismatches = 0;
  int spans_seen = 0;
  int spans_drawn = 0;
  int trapezoids_sent = 0;
  int clip_settings = 0;
  int quiet_cycles = 0;
  int unsigned stall_clock = 0;

  clipped_trapezoid_span_gen i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Round a fixed-point edge to the nearest pixel, halves going up.
  function automatic int pixel_of(logic signed [31:0] x);
    longint s;
    s = longint'(x) + (longint'(1) <<< (FRAC - 1));
    return int'(s >>> FRAC);
  endfunction

  // Expected spans of one trapezoid under the current clip window.
  function automatic void predict_spans(in_t t);
    logic [31:0] ax, bx;
    logic [15:0] row;
    int          count, lines, y, p1, p2, tmp;
    int          lo_x, hi_x, lo_y, hi_y;
    out_t        s;
    lo_x  = $signed(clip_now.left);
    hi_x  = $signed(clip_now.right);
    lo_y  = $signed(clip_now.top);
    hi_y  = $signed(clip_now.bottom);
    ax    = t.edge_a_x;
    bx    = t.edge_b_x;
    row   = t.start_row;
    count = (t.line_count > LINE_CAP) ? LINE_CAP : int'(t.line_count);
    lines = (count == 0) ? 1 : count;
    for (int k = 0; k < lines; k++) begin
      s = '0;
      s.span_row = row;
      if (count != 0) begin
        y = $signed(row);
        if (y >= lo_y && y < hi_y) begin
          p1 = pixel_of(ax);
          p2 = pixel_of(bx);
          if (p2 < p1) begin
            tmp = p1;
            p1  = p2;
            p2  = tmp;
          end
          if (p1 < lo_x) p1 = lo_x;
          if (p2 > hi_x) p2 = hi_x;
          if (p1 < p2) begin
            s.draw       = 1'b1;
            s.span_x     = p1[15:0];
            s.span_width = 16'(p2 - p1);
          end
        end
        ax  = ax + t.edge_a_step;
        bx  = bx + t.edge_b_step;
        row = row + 16'd1;
      end
      if (k == lines - 1) begin
        s.last    = 1'b1;
        s.end_a_x = ax;
        s.end_b_x = bx;
        s.end_row = row;
      end
      spans_due.push_back(s);
    end
  endfunction

  function automatic in_t trap(logic [31:0] ax, logic [31:0] bx, logic [31:0] sa,
                               logic [31:0] sb, logic [15:0] row, logic [6:0] n);
    in_t t;
    t.edge_a_x    = ax;
    t.edge_b_x    = bx;
    t.edge_a_step = sa;
    t.edge_b_step = sb;
    t.start_row   = row;
    t.line_count  = n;
    return t;
  endfunction

  function automatic clip_t window(int l, int r, int t, int b);
    clip_t c;
    c.left   = l[15:0];
    c.right  = r[15:0];
    c.top    = t[15:0];
    c.bottom = b[15:0];
    return c;
  endfunction

  function automatic plan_row_t row_of(in_t t);
    plan_row_t p;
    p.trap   = t;
    p.known  = 1'b0;
    p.want   = '0;
    p.reclip = 1'b0;
    p.clip   = '0;
    return p;
  endfunction

  // Present one trapezoid and hold it until the block takes it.
  task automatic send_trap(in_t t, bit known, out_t want);
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    trapezoids_sent++;
    if (known) spans_due.push_back(want);
    else predict_spans(t);
  endtask

  // Stop sending and let every owed span come out before touching registers.
  task automatic drain;
    in_valid <= 1'b0;
    while (spans_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all four clip registers, each with a setup and an access phase.
  // Consecutive writes run back to back; the bus is released after the last.
  task automatic write_clip(clip_t c);
    logic [15:0] value;
    for (int i = 0; i < 4; i++) begin
      case (reg_idx_e'(i))
        REG_CLIP_LEFT:   value = c.left;
        REG_CLIP_RIGHT:  value = c.right;
        REG_CLIP_TOP:    value = c.top;
        REG_CLIP_BOTTOM: value = c.bottom;
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx_e'(i), 2'b00};
      pwdata  <= {{16{value[15]}}, value};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    clip_now = c;
    clip_settings++;
  endtask

  // Check one field of a span and report any difference.
  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
    end
  endtask

  // The receiver cycles through steady, random, periodic and sparse stalls.
  always @(posedge clk) begin
    stall_clock <= stall_clock + 1;
    case (stall_clock[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 9) < 7);
      2'd2: out_ready <= (stall_clock[1:0] == 2'd0);
      default: out_ready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  // Compare every span that leaves the block with the oldest one owed.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      spans_seen++;
      if (out_data.draw) spans_drawn++;
      if (spans_due.size() == 0) begin
        mismatches++;
        $display("%0t: span with none owed, actual %h", $time, out_data);
      end else begin
        want = spans_due.pop_front();
        check_field("draw", want.draw, out_data.draw);
        check_field("span_x", want.span_x, out_data.span_x);
        check_field("span_row", want.span_row, out_data.span_row);
        check_field("span_width", want.span_width, out_data.span_width);
        check_field("last", want.last, out_data.last);
        check_field("end_a_x", want.end_a_x, out_data.end_a_x);
        check_field("end_b_x", want.end_b_x, out_data.end_b_x);
        check_field("end_row", want.end_row, out_data.end_row);
      end
    end
  end

  // Give up when nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    plan_row_t   r;
    in_t         t;
    bit          steady;
    int          burst_left, gap, pick, base_a, base_b, base_y, l, top;
    logic [31:0] sa, sb;
    logic [6:0]  n;

    // Directed table: clip window still at its reset value first.
    r = row_of(trap(32'h0001_8000, 32'h0005_0000, 32'h0001_0000, 32'hFFFF_0000,
                    -16'sd5, 7'd0));
    r.known = 1'b1;
    r.want.span_row = -16'sd5;
    r.want.last = 1'b1;
    r.want.end_a_x = 32'h0001_8000;
    r.want.end_b_x = 32'h0005_0000;
    r.want.end_row = -16'sd5;
    plan.push_back(r);
    r = row_of(trap(32'h0003_0000, 32'h0009_0000, 32'h0, 32'h0, -16'sd5, 7'd1));
    r.known = 1'b1;
    r.want.span_row = -16'sd5;
    r.want.last = 1'b1;
    r.want.end_a_x = 32'h0003_0000;
    r.want.end_b_x = 32'h0009_0000;
    r.want.end_row = -16'sd4;
    plan.push_back(r);
    plan.push_back(row_of(trap(32'h0002_0000, 32'h0004_0000, 32'h0000_4000, 32'h0,
                               16'sd0, 7'd127)));

    // A small window: swapped edges, half-pixel rounding, wraps, counts.
    r = row_of(trap(32'h0010_0000, 32'h0002_8000, 32'h0001_0000, 32'hFFFF_8000,
                    -16'sd8, 7'd20));
    r.reclip = 1'b1;
    r.clip = window(-10, 100, -5, 40);
    plan.push_back(r);
    r = row_of(trap(32'h0000_8000, 32'hFFFF_8000, 32'h0, 32'h0, 16'sd0, 7'd1));
    r.known = 1'b1;
    r.want.draw = 1'b1;
    r.want.span_width = 16'd1;
    r.want.last = 1'b1;
    r.want.end_a_x = 32'h0000_8000;
    r.want.end_b_x = 32'hFFFF_8000;
    r.want.end_row = 16'sd1;
    plan.push_back(r);
    plan.push_back(row_of(trap(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h8000_0000, 16'sd0, 7'd3)));
    plan.push_back(row_of(trap(32'h0005_0000, 32'h0030_0000, 32'h0, 32'h0,
                               16'sd32767, 7'd4)));
    plan.push_back(row_of(trap(32'hFFF0_0000, 32'h0060_0000, 32'h0000_C000,
                               32'hFFFF_4000, -16'sd20, 7'd64)));
    plan.push_back(row_of(trap(32'h0000_0000, 32'h0050_0000, 32'h0000_2000,
                               32'h0000_1000, -16'sd30, 7'd65)));
    plan.push_back(row_of(trap(32'h0007_4000, 32'h0007_4000, 32'h0001_0000,
                               32'h0001_0000, 16'sd3, 7'd2)));
    r = row_of(trap(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    -16'sd1, 7'd0));
    r.known = 1'b1;
    r.want.span_row = -16'sd1;
    r.want.last = 1'b1;
    r.want.end_a_x = 32'hFFFF_FFFF;
    r.want.end_b_x = 32'hFFFF_FFFF;
    r.want.end_row = -16'sd1;
    plan.push_back(r);

    // The widest window: full-screen span and rows at both ends.
    r = row_of(trap(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 16'sd0, 7'd1));
    r.reclip = 1'b1;
    r.clip = window(-32768, 32767, -32768, 32767);
    r.known = 1'b1;
    r.want.draw = 1'b1;
    r.want.span_x = -16'sd32768;
    r.want.span_width = 16'hFFFF;
    r.want.last = 1'b1;
    r.want.end_a_x = 32'h8000_0000;
    r.want.end_b_x = 32'h7FFF_FFFF;
    r.want.end_row = 16'sd1;
    plan.push_back(r);
    plan.push_back(row_of(trap(32'h1234_5678, 32'hEDCB_A987, 32'h0100_0000,
                               32'hFF00_0000, -16'sd32768, 7'd2)));
    plan.push_back(row_of(trap(32'h0000_0000, 32'h0000_FFFF, 32'h0000_8000,
                               32'h0000_8000, 16'sd32766, 7'd3)));

    // Inverted columns, then inverted rows: nothing may be drawn.
    r = row_of(trap(32'h0000_0000, 32'h000A_0000, 32'h0001_0000, 32'h0, 16'sd0, 7'd5));
    r.reclip = 1'b1;
    r.clip = window(50, -50, -100, 100);
    plan.push_back(r);
    r = row_of(trap(32'hFFF6_0000, 32'h000A_0000, 32'h0, 32'h0, 16'sd0, 7'd4));
    r.reclip = 1'b1;
    r.clip = window(-100, 100, 10, -10);
    plan.push_back(r);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table back to back.
    foreach (plan[i]) begin
      if (plan[i].reclip) begin
        drain();
        write_clip(plan[i].clip);
      end
      send_trap(plan[i].trap, plan[i].known, plan[i].want);
    end

    // Random part: a new clip window per phase, sender in bursts.
    burst_left = 0;
    steady = 1'b0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0) begin
        drain();
        steady = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 4);
        l = int'($urandom_range(0, 300)) - 200;
        top = int'($urandom_range(0, 100)) - 50;
        case (pick)
          0: write_clip(window(-32768, 32767, -32768, 32767));
          1: write_clip(window($urandom, $urandom, $urandom, $urandom));
          2: write_clip(window(l, l + int'($urandom_range(0, 400)), top,
                               top + int'($urandom_range(0, 80))));
          3: write_clip(window(l, l - int'($urandom_range(1, 100)), top,
                               top + int'($urandom_range(0, 80))));
          default: write_clip(window(l, l + int'($urandom_range(0, 400)), top, top));
        endcase
      end

      // Mostly small trapezoids landing on the window, some pure noise.
      pick = $urandom_range(0, 9);
      n = (pick < 7) ? 7'($urandom_range(0, 12)) :
          (pick < 9) ? 7'($urandom_range(13, 64)) : 7'($urandom_range(0, 127));
      if ($urandom_range(0, 4) != 0) begin
        base_a = int'($signed(clip_now.left)) + int'($urandom_range(0, 500)) - 50;
        base_b = int'($signed(clip_now.left)) + int'($urandom_range(0, 500)) - 50;
        base_y = int'($signed(clip_now.top)) + int'($urandom_range(0, 40)) - 10;
        sa = 32'(int'($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
        sb = 32'(int'($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
        t = trap({base_a[15:0], 16'($urandom)}, {base_b[15:0], 16'($urandom)}, sa, sb,
                 base_y[15:0], n);
      end else begin
        t = trap($urandom, $urandom, $urandom, $urandom, 16'($urandom), n);
      end

      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        case ($urandom_range(0, 3))
          0: gap = 0;
          1: gap = $urandom_range(1, 2);
          2: gap = $urandom_range(3, 12);
          default: gap = 0;
        endcase
        if (!steady && gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      send_trap(t, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (spans_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d trapezoids (%0d from the directed table) over %0d clip windows.",
             trapezoids_sent, plan.size(), clip_settings);
    $display("Checked %0d spans, %0d of them drawn; %0d field mismatches.",
             spans_seen, spans_drawn, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
